FILE: src/ohi_pkg.sv
// Shared types and constants for the open addressing hash index.
`timescale 1ns / 1ps
package ohi_pkg;

  localparam int Slots = 64;
  localparam int SlotBits = $clog2(Slots);
  localparam int KeyBytes = 8;
  localparam int ValueWidth = 16;
  localparam int CountWidth = $clog2(Slots + 1);

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_UPSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_OCC = 2'd1;
  localparam logic [1:0] SLOT_TOMB = 2'd2;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  typedef struct packed {
    logic [1:0] action;
    logic [63:0] key;
    logic [3:0] key_len;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] found_value;
    logic [6:0] entries;
  } rsp_t;

  // Hashed request handed from the front part to the back part.
  typedef struct packed {
    logic [1:0] action;
    logic [63:0] key;
    logic [3:0] key_len;
    logic [ValueWidth-1:0] value;
    logic [31:0] hash;
  } job_t;

endpackage

FILE: src/ohi_front.sv
// Front part: normalizes the key and hashes it one byte per cycle.
`timescale 1ns / 1ps
module ohi_front
  import ohi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  logic busy;
  logic done;
  logic [3:0] idx;
  logic [31:0] prod;
  logic [7:0] cur;

  assign full = busy;
  assign job_valid = done;
  assign cur = job.key[{idx[2:0], 3'b000} +: 8];
  assign prod = (job.hash ^ {24'd0, cur}) * FnvPrime;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (!busy && push) begin
      busy <= 1'b1;
      done <= 1'b0;
      idx <= 4'd0;
      job.action <= req.action;
      job.value <= req.value[ValueWidth-1:0];
      job.hash <= FnvBasis;
      for (int b = 0; b < KeyBytes; b++) begin
        job.key[b*8 +: 8] <= (b < req.key_len) ? req.key[b*8 +: 8] : 8'd0;
      end
      job.key_len <= (req.key_len > 4'(KeyBytes)) ? 4'(KeyBytes) : req.key_len;
    end else if (busy && !done) begin
      if (idx == job.key_len) begin
        done <= 1'b1;
      end else begin
        job.hash <= prod;
        idx <= idx + 4'd1;
      end
    end else if (done && job_ready) begin
      done <= 1'b0;
      busy <= 1'b0;
    end
  end

endmodule

FILE: src/ohi_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module ohi_queue
  import ohi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);

  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign in_ready = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_job = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wp] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        wp <= ~wp;
      end
      if (out_valid && out_ready) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

FILE: src/ohi_back.sv
// Back part: probes the slot memory, updates it and holds the response.
`timescale 1ns / 1ps
module ohi_back
  import ohi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  typedef struct packed {
    logic [31:0] hash;
    logic [63:0] key;
    logic [3:0] key_len;
    logic [ValueWidth-1:0] value;
  } slot_t;

  slot_t slot_mem [Slots];
  slot_t rd;
  logic [1:0] stat [Slots];
  logic [1:0] rd_stat;

  logic [2:0] state;
  job_t cur;
  logic [SlotBits-1:0] pos, free_pos, hit_pos;
  logic [CountWidth-1:0] steps;
  logic have_free, hit;
  logic [CountWidth-1:0] count;
  logic rsp_valid;
  logic match;
  logic wr_en;
  logic [SlotBits-1:0] wr_addr;
  slot_t wr_data;

  logic finish;
  rsp_t rsp_next;
  logic [CountWidth-1:0] count_next;
  logic mem_en;
  logic [SlotBits-1:0] mem_addr;
  logic stat_en;
  logic [SlotBits-1:0] stat_addr;
  logic [1:0] stat_val;

  assign job_ready = state == S_IDLE;
  assign empty = !rsp_valid;
  assign match = rd_stat == SLOT_OCC && rd.hash == cur.hash &&
                 rd.key_len == cur.key_len && rd.key == cur.key;
  assign finish = state == S_DONE && (!rsp_valid || pop);

  // Outcome of the finished probe: the response and the table updates.
  always_comb begin
    rsp_next = '0;
    rsp_next.status = ST_OK;
    count_next = count;
    mem_en = 1'b0;
    mem_addr = hit_pos;
    stat_en = 1'b0;
    stat_addr = hit_pos;
    stat_val = SLOT_TOMB;
    case (cur.action)
      ACT_UPSERT: begin
        if (hit) begin
          mem_en = 1'b1;
        end else if ((32'(count) + 32'd1) * 32'd4 >= 32'(Slots * 3) || !have_free) begin
          rsp_next.status = ST_FULL;
        end else begin
          mem_en = 1'b1;
          mem_addr = free_pos;
          stat_en = 1'b1;
          stat_addr = free_pos;
          stat_val = SLOT_OCC;
          count_next = count + CountWidth'(1);
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          stat_en = 1'b1;
          count_next = count - CountWidth'(1);
        end else begin
          rsp_next.status = ST_MISS;
        end
      end
      default: begin
        if (hit) begin
          rsp_next.found_value = 16'(rd.value);
        end else begin
          rsp_next.status = ST_MISS;
        end
      end
    endcase
    rsp_next.entries = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    rd <= slot_mem[pos];
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      count <= '0;
      wr_en <= 1'b0;
      for (int i = 0; i < Slots; i++) begin
        stat[i] <= SLOT_EMPTY;
      end
    end else begin
      wr_en <= finish && mem_en;
      if (finish) begin
        rsp_valid <= 1'b1;
        rsp <= rsp_next;
        count <= count_next;
        wr_addr <= mem_addr;
        wr_data <= '{hash: cur.hash, key: cur.key, key_len: cur.key_len,
                     value: cur.value};
        if (stat_en) begin
          stat[stat_addr] <= stat_val;
        end
      end else if (rsp_valid && pop) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            pos <= job.hash[SlotBits-1:0];
            steps <= '0;
            have_free <= 1'b0;
            hit <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          rd_stat <= stat[pos];
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_stat == SLOT_EMPTY) begin
            if (!have_free) begin
              free_pos <= pos;
              have_free <= 1'b1;
            end
            state <= S_DONE;
          end else if (match) begin
            hit <= 1'b1;
            hit_pos <= pos;
            state <= S_DONE;
          end else begin
            if (rd_stat == SLOT_TOMB && !have_free) begin
              free_pos <= pos;
              have_free <= 1'b1;
            end
            if (steps == CountWidth'(Slots - 1)) begin
              state <= S_DONE;
            end else begin
              steps <= steps + CountWidth'(1);
              pos <= pos + SlotBits'(1);
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/open_addressing_hash_index_unit.sv
// Top level of the open addressing hash index.
`timescale 1ns / 1ps
// The block keeps a 64-slot keyed index with linear probing and tombstones.
// Requests enter through a queue-like port: a request is taken at a clock
// edge where push is high and full is low. Each request carries an action
// (lookup, upsert, remove), a key of up to 8 bytes, its length and a value.
// Responses leave the same way: while empty is low the oldest response is on
// rsp, and pop takes it.
// The front part hashes the key with FNV-1a, one key byte per cycle. A
// two-entry queue follows, then the back part takes the request, probes the
// slot memory by reading and then checking each slot visited, and finishes;
// the cost of a request is set by the byte-serial hash and the single memory
// read port.
// The front part hashes the next request while the back part probes, and the
// back part holds its finished response in a register, so a stalled receiver
// only blocks the back part once it has a second response ready.
// A synchronous reset marks all slots empty and clears the entry count at
// once; no clearing pass is needed.
module open_addressing_hash_index_unit
  import ohi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  ohi_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  ohi_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_ready(f_ready),
    .in_job(f_job), .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
  );

  ohi_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_valid), .job_ready(q_ready),
    .job(q_job), .empty(empty), .pop(pop), .rsp(rsp)
  );

endmodule
